// ===== src/psgwt_pkg.sv =====
// Shared types and constants for the sound generator write-event tracker.
`default_nettype none

package psgwt_pkg;

    localparam int unsigned NUM_VOICES = 4;

    localparam int unsigned LATCH_BIT   = 7;
    localparam logic [3:0]  NIBBLE_MAX  = 4'hF;
    localparam logic [1:0]  NOISE_VOICE = 2'd3;

    // Architectural state of the tracker
    typedef struct packed {
        logic [2:0]                       latched;
        logic [NUM_VOICES-1:0][9:0]       period;
        logic [NUM_VOICES-1:0]            sounding;
    } psgwt_state_t;

    // Key event produced by one write
    typedef struct packed {
        logic       fire;
        logic [1:0] voice;
        logic       key_on;
        logic [9:0] period;
    } psgwt_event_t;

endpackage

`default_nettype wire

// ===== src/psgwt_decode.sv =====
// Combinational decode of one write byte against the tracker state.
`default_nettype none

module psgwt_decode
(
    input  wire logic [7:0]             write_byte,
    input  wire psgwt_pkg::psgwt_state_t state_cur,
    output psgwt_pkg::psgwt_state_t     state_nxt,
    output psgwt_pkg::psgwt_event_t     event_out
);

    logic       latch;
    logic [2:0] reg_sel;
    logic [1:0] ch;
    logic       on;

    always_comb
    begin
        latch   = write_byte[psgwt_pkg::LATCH_BIT];
        reg_sel = latch ? write_byte[6:4] : state_cur.latched;
        ch      = reg_sel[2:1];
        on      = (write_byte[3:0] != psgwt_pkg::NIBBLE_MAX);

        state_nxt         = state_cur;
        state_nxt.latched = reg_sel;

        event_out        = '0;
        event_out.voice  = ch;

        if (reg_sel[0])
        begin
            // attenuation register: report only a change of the sounding mark
            if (on != state_cur.sounding[ch])
            begin
                state_nxt.sounding[ch] = on;
                event_out.fire         = 1'b1;
                event_out.key_on       = on;
            end
        end
        else if (latch || (ch == psgwt_pkg::NOISE_VOICE))
        begin
            // low nibble of period; noise takes every non-attenuation byte this way
            state_nxt.period[ch][3:0] = write_byte[3:0];
        end
        else
        begin
            state_nxt.period[ch][9:4] = write_byte[5:0];
            event_out.fire            = state_cur.sounding[ch];
            event_out.key_on          = 1'b1;
        end

        event_out.period = state_nxt.period[ch];
    end

endmodule

`default_nettype wire

// ===== src/psg_write_note_event_tracker.sv =====
// Top level: write-event tracker for a four-channel sound generator.
// A write passes the input register and then the result register before the port.
// Throughput: one write per cycle; the input register feeds a single decode
// pass into the result register, and the input stalls only while a result waits.
// Reset (rst_n, async, active low) clears the latched register number, all
// periods, all sounding marks and both valid flags.
`default_nettype none

module psg_write_note_event_tracker
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // write stream
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  write_byte,
    input  wire logic [31:0] stamp_in,

    // key events
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       voice,
    output logic             key_on,
    output logic [9:0]       tone_period,
    output logic [31:0]      stamp_out
);

    // input register
    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic [31:0] stamp_reg;

    // tracker state
    psgwt_pkg::psgwt_state_t state_reg;
    psgwt_pkg::psgwt_state_t state_next;
    psgwt_pkg::psgwt_event_t ev;

    // result register
    logic        out_valid_reg;
    logic [1:0]  voice_reg;
    logic        key_on_reg;
    logic [9:0]  period_reg;
    logic [31:0] stamp_out_reg;

    // the held write is processed whenever the result slot is free or draining
    logic go;

    assign go       = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && !go;

    psgwt_decode u_decode
    (
        .write_byte (byte_reg),
        .state_cur  (state_reg),
        .state_nxt  (state_next),
        .event_out  (ev)
    );

    // input stage: capture a new write whenever the held one moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            byte_reg  <= write_byte;
            stamp_reg <= stamp_in;
        end
    end

    // state commits once per processed write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (go)
        begin
            state_reg <= state_next;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go)
        begin
            out_valid_reg <= ev.fire;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && ev.fire)
        begin
            voice_reg     <= ev.voice;
            key_on_reg    <= ev.key_on;
            period_reg    <= ev.period;
            stamp_out_reg <= stamp_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign voice       = voice_reg;
    assign key_on      = key_on_reg;
    assign tone_period = period_reg;
    assign stamp_out   = stamp_out_reg;

`ifndef ASSERT_OFF
    a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (go && ev.fire) |=> out_valid)
        else $error("event lost after decode");

    a_stamp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (go && ev.fire) |=> (stamp_out == $past(stamp_reg)))
        else $error("event stamp mismatch");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !go |=> $stable(state_reg))
        else $error("state changed without a processed write");

    a_period_match: assert property (@(posedge clk) disable iff (!rst_n)
        (go && ev.fire) |=> (tone_period == state_reg.period[voice]))
        else $error("event period differs from stored period");
`endif

endmodule

`default_nettype wire
